@@ sv/wls_pkg.sv @@
// shared types, constants and register map of the weighted laplacian stencil
package wls_pkg;

    localparam int MAX_ROW_DEF    = 64;
    localparam int MAX_ROWS_DEF   = 64;
    localparam int MAX_PLANES_DEF = 8;
    localparam int FOURTH_LIMIT   = 4096;
    localparam int FOURTH_W       = 13;
    localparam int FOURTH_POS_W   = 12;

    localparam int SAMPLE_W  = 24;
    localparam int WEIGHT_W  = 16;
    localparam int VALUE_W   = 32;
    localparam int FRAC_BITS = 12;
    localparam int NTAP      = 9;
    localparam int NNB       = NTAP - 1;

    localparam int PADDR_W = 5;

    localparam logic [2:0] REG_SIZE_FIRST    = 3'd0;
    localparam logic [2:0] REG_SIZE_SECOND   = 3'd1;
    localparam logic [2:0] REG_SIZE_THIRD    = 3'd2;
    localparam logic [2:0] REG_SIZE_FOURTH   = 3'd3;
    localparam logic [2:0] REG_WEIGHT_FIRST  = 3'd4;
    localparam logic [2:0] REG_WEIGHT_SECOND = 3'd5;
    localparam logic [2:0] REG_WEIGHT_THIRD  = 3'd6;
    localparam logic [2:0] REG_WEIGHT_FOURTH = 3'd7;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_DRAIN  = 1'b1;

    // per-result control handed from the address stage to the arithmetic
    typedef struct packed {
        logic [NNB-1:0]             nb_en;
        logic [NTAP-1:0]            fwd;
        logic signed [SAMPLE_W-1:0] wdata;
        logic                       last;
    } tap_ctl_t;

endpackage

@@ sv/wls_window.sv @@
// sample window store: one copy per tap, common write, registered reads
module wls_window #(
    parameter int DEPTH = 2 * wls_pkg::MAX_ROW_DEF * wls_pkg::MAX_ROWS_DEF
                          * wls_pkg::MAX_PLANES_DEF + 1,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [AW-1:0]                         waddr,
    input  logic [wls_pkg::SAMPLE_W-1:0]          wdata,
    input  logic                                  re,
    input  logic [wls_pkg::NTAP-1:0][AW-1:0]      raddr,
    output logic [wls_pkg::NTAP-1:0][wls_pkg::SAMPLE_W-1:0] rdata
);

    for (genvar t = 0; t < wls_pkg::NTAP; t++) begin : g_bank
        logic [wls_pkg::SAMPLE_W-1:0] mem [DEPTH];

        always_ff @(posedge aclk) begin
            if (we) begin
                mem[waddr] <= wdata;
            end
        end

        always_ff @(posedge aclk) begin
            if (re) begin
                rdata[t] <= mem[raddr[t]];
            end
        end
    end

endmodule

@@ sv/wls_datapath.sv @@
// tap merge, weighted differences, adder tree, rounding and output register
module wls_datapath (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  wls_pkg::tap_ctl_t                     in_ctl,
    input  logic [wls_pkg::NTAP-1:0][wls_pkg::SAMPLE_W-1:0] rdata,
    input  logic [3:0][wls_pkg::WEIGHT_W-1:0]     weight,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [wls_pkg::VALUE_W-1:0]           out_value,
    output logic                                  out_last
);

    localparam int DW   = wls_pkg::SAMPLE_W + 1;
    localparam int PW   = DW + wls_pkg::WEIGHT_W + 1;
    localparam int QW   = PW + 1;
    localparam int SW   = QW + 2;
    localparam int VW   = wls_pkg::VALUE_W;

    localparam logic signed [SW-1:0] VMAX = SW'((64'sd1 <<< (VW - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] VMIN = -SW'(64'sd1 <<< (VW - 1));

    logic              v1_reg, v2_reg, v3_reg, vo_reg;
    logic              rdy1, rdy2, rdy3, rdyo;
    wls_pkg::tap_ctl_t ctl1_reg;
    logic              last2_reg, last3_reg, last_o_reg;
    logic signed [PW-1:0] prod_reg [wls_pkg::NNB];
    logic signed [PW-1:0] prod_next [wls_pkg::NNB];
    logic signed [QW-1:0] pair_reg [4];
    logic [VW-1:0]        value_reg, value_next;

    logic signed [wls_pkg::SAMPLE_W-1:0] tap [wls_pkg::NTAP];
    logic signed [SW-1:0] sum;
    logic signed [SW-1:0] rnd;

    assign rdyo     = !vo_reg || out_ready;
    assign rdy3     = !v3_reg || rdyo;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // a tap written in the same cycle as its read takes the write data
    always_comb begin
        for (int t = 0; t < wls_pkg::NTAP; t++) begin
            tap[t] = ctl1_reg.fwd[t] ? ctl1_reg.wdata : $signed(rdata[t]);
        end
        for (int k = 0; k < wls_pkg::NNB; k++) begin
            if (ctl1_reg.nb_en[k]) begin
                prod_next[k] = PW'(DW'(tap[k+1]) - DW'(tap[0]))
                               * PW'($signed({1'b0, weight[k/2]}));
            end else begin
                prod_next[k] = '0;
            end
        end
    end

    always_comb begin
        sum = SW'(pair_reg[0]) + SW'(pair_reg[1]) + SW'(pair_reg[2]) + SW'(pair_reg[3]);
        rnd = (sum + SW'(2 ** (wls_pkg::FRAC_BITS - 1))) >>> wls_pkg::FRAC_BITS;
        if (rnd > VMAX) begin
            value_next = {1'b0, {(VW-1){1'b1}}};
        end else if (rnd < VMIN) begin
            value_next = {1'b1, {(VW-1){1'b0}}};
        end else begin
            value_next = rnd[VW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdyo) vo_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            ctl1_reg <= in_ctl;
        end
        if (rdy2 && v1_reg) begin
            prod_reg  <= prod_next;
            last2_reg <= ctl1_reg.last;
        end
        if (rdy3 && v2_reg) begin
            for (int i = 0; i < 4; i++) begin
                pair_reg[i] <= QW'(prod_reg[2*i]) + QW'(prod_reg[2*i+1]);
            end
            last3_reg <= last2_reg;
        end
        if (rdyo && v3_reg) begin
            value_reg  <= value_next;
            last_o_reg <= last3_reg;
        end
    end

    assign out_valid = vo_reg;
    assign out_value = value_reg;
    assign out_last  = last_o_reg;

endmodule

@@ sv/weighted_laplacian_stencil.sv @@
// Weighted Laplacian stencil over a raster-order grid of up to four dimensions with
// Neumann edges. One transaction is taken per cycle (sample or drain) whenever the
// result pipeline has room and no size write is settling; a result released by a
// transaction passes through the window store read at the accepting edge, a register
// for the weighted differences, one for the adder tree and the output register after
// rounding.
// The window holds 2*MAX_ROW*MAX_ROWS*MAX_PLANES+1 samples in a store with one
// read copy per stencil tap. After a write of any size register the sample port is
// held off while the plane and grid sizes are recomputed.
module weighted_laplacian_stencil #(
    parameter int MAX_ROW    = wls_pkg::MAX_ROW_DEF,
    parameter int MAX_ROWS   = wls_pkg::MAX_ROWS_DEF,
    parameter int MAX_PLANES = wls_pkg::MAX_PLANES_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [23:0]                  s_tdata,   // sample[23:0]
    input  logic [0:0]                   s_tuser,   // command[0]
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [31:0]                  m_tdata,   // value[31:0]
    output logic                         m_tlast,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [wls_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    localparam int DEPTH = 2 * MAX_ROW * MAX_ROWS * MAX_PLANES + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int N0W   = $clog2(MAX_ROW + 1);
    localparam int N1W   = $clog2(MAX_ROWS + 1);
    localparam int N2W   = $clog2(MAX_PLANES + 1);
    localparam int N3W   = wls_pkg::FOURTH_W;
    localparam int S2W   = N0W + N1W;
    localparam int S3W   = S2W + N2W;
    localparam int CW    = S3W + N3W;
    localparam int P0W   = $clog2(MAX_ROW);
    localparam int P1W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int P2W   = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
    localparam int P3W   = wls_pkg::FOURTH_POS_W;

    logic [6:0]  size_first_reg, size_second_reg;
    logic [3:0]  size_third_reg;
    logic [12:0] size_fourth_reg;
    logic [3:0][wls_pkg::WEIGHT_W-1:0] weight_reg;
    logic [1:0]  settle_reg;

    logic [N0W-1:0] n0;
    logic [N1W-1:0] n1;
    logic [N2W-1:0] n2;
    logic [N3W-1:0] n3;
    logic [S2W-1:0] s2_reg;
    logic [S3W-1:0] s3_reg;
    logic [CW-1:0]  tot_reg;
    logic [CW-1:0]  lead;

    logic [CW-1:0]  in_cnt_reg, out_cnt_reg;
    logic [AW-1:0]  wptr_reg, optr_reg;
    logic [P0W-1:0] pos0_reg;
    logic [P1W-1:0] pos1_reg;
    logic [P2W-1:0] pos2_reg;
    logic [P3W-1:0] pos3_reg;

    logic cfg_wr, size_wr;
    logic acc, we, issue, ready_cond, last;
    logic wdp_ready;
    logic [CW:0] in_after, need;

    logic [wls_pkg::NTAP-1:0][AW-1:0] raddr;
    logic [wls_pkg::NTAP-1:0][wls_pkg::SAMPLE_W-1:0] rdata;
    logic [3:0][AW-1:0] off;
    wls_pkg::tap_ctl_t ctl;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign size_wr = cfg_wr && (paddr[4:2] == wls_pkg::REG_SIZE_FIRST
                             || paddr[4:2] == wls_pkg::REG_SIZE_SECOND
                             || paddr[4:2] == wls_pkg::REG_SIZE_THIRD
                             || paddr[4:2] == wls_pkg::REG_SIZE_FOURTH);

    always_comb begin
        unique case (paddr[4:2])
            wls_pkg::REG_SIZE_FIRST:    prdata = 32'(size_first_reg);
            wls_pkg::REG_SIZE_SECOND:   prdata = 32'(size_second_reg);
            wls_pkg::REG_SIZE_THIRD:    prdata = 32'(size_third_reg);
            wls_pkg::REG_SIZE_FOURTH:   prdata = 32'(size_fourth_reg);
            wls_pkg::REG_WEIGHT_FIRST:  prdata = 32'(weight_reg[0]);
            wls_pkg::REG_WEIGHT_SECOND: prdata = 32'(weight_reg[1]);
            wls_pkg::REG_WEIGHT_THIRD:  prdata = 32'(weight_reg[2]);
            wls_pkg::REG_WEIGHT_FOURTH: prdata = 32'(weight_reg[3]);
            default:                    prdata = '0;
        endcase
    end

    // zero acts as one, too large saturates
    always_comb begin
        if (size_first_reg == '0)              n0 = N0W'(1);
        else if (int'(size_first_reg) > MAX_ROW) n0 = N0W'(MAX_ROW);
        else                                   n0 = N0W'(size_first_reg);
        if (size_second_reg == '0)               n1 = N1W'(1);
        else if (int'(size_second_reg) > MAX_ROWS) n1 = N1W'(MAX_ROWS);
        else                                     n1 = N1W'(size_second_reg);
        if (size_third_reg == '0)                 n2 = N2W'(1);
        else if (int'(size_third_reg) > MAX_PLANES) n2 = N2W'(MAX_PLANES);
        else                                      n2 = N2W'(size_third_reg);
        if (size_fourth_reg == '0)                          n3 = N3W'(1);
        else if (int'(size_fourth_reg) > wls_pkg::FOURTH_LIMIT)
            n3 = N3W'(wls_pkg::FOURTH_LIMIT);
        else                                                n3 = size_fourth_reg;
    end

    // distance from a point to its farthest forward neighbour
    always_comb begin
        if (n3 > N3W'(1))      lead = CW'(s3_reg);
        else if (n2 > N2W'(1)) lead = CW'(s2_reg);
        else if (n1 > N1W'(1)) lead = CW'(n0);
        else if (n0 > N0W'(1)) lead = CW'(1);
        else                   lead = '0;
    end

    assign s_tready = (settle_reg == '0) && wdp_ready;

    assign acc      = s_tvalid && s_tready;
    assign we       = acc && (s_tuser[0] == wls_pkg::CMD_SAMPLE) && (in_cnt_reg < tot_reg);
    assign in_after = (CW+1)'(in_cnt_reg) + (CW+1)'(we);
    always_comb begin
        need = (CW+1)'(out_cnt_reg) + (CW+1)'(lead) + (CW+1)'(1);
        if (need > (CW+1)'(tot_reg)) need = (CW+1)'(tot_reg);
        if (s_tuser[0] == wls_pkg::CMD_SAMPLE) begin
            ready_cond = (out_cnt_reg < tot_reg) && (in_after >= need);
        end else begin
            ready_cond = (out_cnt_reg < tot_reg) && (in_cnt_reg >= tot_reg);
        end
    end
    assign issue = acc && ready_cond;
    assign last  = ((CW+1)'(out_cnt_reg) + (CW+1)'(1)) == (CW+1)'(tot_reg);

    assign off[0] = AW'(1);
    assign off[1] = AW'(n0);
    assign off[2] = AW'(s2_reg);
    assign off[3] = AW'(s3_reg);

    // tap addresses around the output point, wrapped into the window
    always_comb begin
        logic [AW:0] up;
        raddr[0] = optr_reg;
        for (int d = 0; d < 4; d++) begin
            if (optr_reg >= off[d]) raddr[2*d+1] = optr_reg - off[d];
            else raddr[2*d+1] = AW'((AW+1)'(optr_reg) + (AW+1)'(DEPTH) - (AW+1)'(off[d]));
            up = (AW+1)'(optr_reg) + (AW+1)'(off[d]);
            if (up >= (AW+1)'(DEPTH)) raddr[2*d+2] = AW'(up - (AW+1)'(DEPTH));
            else raddr[2*d+2] = AW'(up);
        end
    end

    always_comb begin
        ctl.nb_en[0] = pos0_reg != '0;
        ctl.nb_en[1] = 32'(pos0_reg) + 32'd1 < 32'(n0);
        ctl.nb_en[2] = pos1_reg != '0;
        ctl.nb_en[3] = 32'(pos1_reg) + 32'd1 < 32'(n1);
        ctl.nb_en[4] = pos2_reg != '0;
        ctl.nb_en[5] = 32'(pos2_reg) + 32'd1 < 32'(n2);
        ctl.nb_en[6] = pos3_reg != '0;
        ctl.nb_en[7] = 32'(pos3_reg) + 32'd1 < 32'(n3);
        for (int t = 0; t < wls_pkg::NTAP; t++) begin
            ctl.fwd[t] = we && (raddr[t] == wptr_reg);
        end
        ctl.wdata = $signed(s_tdata);
        ctl.last  = last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_first_reg  <= 7'd1;
            size_second_reg <= 7'd1;
            size_third_reg  <= 4'd1;
            size_fourth_reg <= 13'd1;
            weight_reg      <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                wls_pkg::REG_SIZE_FIRST:    size_first_reg  <= pwdata[6:0];
                wls_pkg::REG_SIZE_SECOND:   size_second_reg <= pwdata[6:0];
                wls_pkg::REG_SIZE_THIRD:    size_third_reg  <= pwdata[3:0];
                wls_pkg::REG_SIZE_FOURTH:   size_fourth_reg <= pwdata[12:0];
                wls_pkg::REG_WEIGHT_FIRST:  weight_reg[0]   <= pwdata[15:0];
                wls_pkg::REG_WEIGHT_SECOND: weight_reg[1]   <= pwdata[15:0];
                wls_pkg::REG_WEIGHT_THIRD:  weight_reg[2]   <= pwdata[15:0];
                wls_pkg::REG_WEIGHT_FOURTH: weight_reg[3]   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // plane, volume and grid sizes, one product per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_reg     <= S2W'(1);
            s3_reg     <= S3W'(1);
            tot_reg    <= CW'(1);
            settle_reg <= '0;
        end else begin
            s2_reg  <= S2W'(n0 * n1);
            s3_reg  <= S3W'(s2_reg * n2);
            tot_reg <= CW'(s3_reg * n3);
            if (size_wr) settle_reg <= 2'd3;
            else if (settle_reg != '0) settle_reg <= settle_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || size_wr) begin
            in_cnt_reg  <= '0;
            out_cnt_reg <= '0;
            wptr_reg    <= '0;
            optr_reg    <= '0;
            pos0_reg    <= '0;
            pos1_reg    <= '0;
            pos2_reg    <= '0;
            pos3_reg    <= '0;
        end else if (issue && last) begin
            in_cnt_reg  <= '0;
            out_cnt_reg <= '0;
            wptr_reg    <= '0;
            optr_reg    <= '0;
            pos0_reg    <= '0;
            pos1_reg    <= '0;
            pos2_reg    <= '0;
            pos3_reg    <= '0;
        end else begin
            if (we) begin
                in_cnt_reg <= in_cnt_reg + CW'(1);
                wptr_reg   <= (wptr_reg == AW'(DEPTH - 1)) ? '0 : wptr_reg + AW'(1);
            end
            if (issue) begin
                out_cnt_reg <= out_cnt_reg + CW'(1);
                optr_reg    <= (optr_reg == AW'(DEPTH - 1)) ? '0 : optr_reg + AW'(1);
                if (32'(pos0_reg) + 32'd1 >= 32'(n0)) begin
                    pos0_reg <= '0;
                    if (32'(pos1_reg) + 32'd1 >= 32'(n1)) begin
                        pos1_reg <= '0;
                        if (32'(pos2_reg) + 32'd1 >= 32'(n2)) begin
                            pos2_reg <= '0;
                            pos3_reg <= pos3_reg + P3W'(1);
                        end else begin
                            pos2_reg <= pos2_reg + P2W'(1);
                        end
                    end else begin
                        pos1_reg <= pos1_reg + P1W'(1);
                    end
                end else begin
                    pos0_reg <= pos0_reg + P0W'(1);
                end
            end
        end
    end

    wls_window #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_window (
        .aclk  (aclk),
        .we    (we),
        .waddr (wptr_reg),
        .wdata (s_tdata),
        .re    (issue),
        .raddr (raddr),
        .rdata (rdata)
    );

    wls_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (issue),
        .in_ready  (wdp_ready),
        .in_ctl    (ctl),
        .rdata     (rdata),
        .weight    (weight_reg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_value (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

@@ sv/wls_checker.sv @@
// port-level checks for the weighted laplacian stencil, bound to the top level
module wls_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [31:0]                  m_tdata,
    input logic                         m_tlast,
    input logic                         psel,
    input logic                         penable,
    input logic                         pwrite,
    input logic [wls_pkg::PADDR_W-1:0]  paddr,
    input logic                         pready
);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // reset empties the result pipeline
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a size write holds off samples while the grid sizes settle
    assert property (@(posedge aclk) disable iff (!aresetn)
        psel && penable && pwrite && pready
        && (paddr[4:2] == wls_pkg::REG_SIZE_FIRST || paddr[4:2] == wls_pkg::REG_SIZE_SECOND
         || paddr[4:2] == wls_pkg::REG_SIZE_THIRD || paddr[4:2] == wls_pkg::REG_SIZE_FOURTH)
        |=> !s_tready ##1 !s_tready)
        else $error("samples taken while sizes settle");

    assert property (@(posedge aclk) disable iff (!aresetn) pready)
        else $error("configuration port not ready");

endmodule

bind weighted_laplacian_stencil wls_checker u_wls_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pready   (pready)
);
